[sv/key_value_string_splitter_core_assert.svh]
// Assertion macros used by the checker file of the key/value splitter.
`ifndef KEY_VALUE_STRING_SPLITTER_CORE_ASSERT_SVH
`define KEY_VALUE_STRING_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define KVS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kvs check failed");

// Next-cycle implication, ignored while reset is asserted.
`define KVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kvs check failed");

// Next-cycle implication that is also checked across reset.
`define KVS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("kvs check failed");

`endif

[sv/kvs_pkg.sv]
// ----------------------------------------------------------------------------
// kvs_pkg
// Types, constants and register map of the key/value string splitter.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam int DELIM_MAX_DEF    = 4;
  localparam int OFFSET_WIDTH_DEF = 16;

  localparam int FIELD_W    = 16;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 1;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int LEN_W      = 3;

  // Input op codes. The spare code is handled like an empty row.
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_NULL  = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Result kinds.
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;

  // Register indexes.
  localparam logic [1:0] REG_ENTRY_DELIM     = 2'd0;
  localparam logic [1:0] REG_ENTRY_DELIM_LEN = 2'd1;
  localparam logic [1:0] REG_KV_DELIM        = 2'd2;
  localparam logic [1:0] REG_KV_DELIM_LEN    = 2'd3;

  localparam logic [31:0]      ENTRY_DELIM_RST     = 32'd44;
  localparam logic [LEN_W-1:0] ENTRY_DELIM_LEN_RST = 3'd1;
  localparam logic [31:0]      KV_DELIM_RST        = 32'd61;
  localparam logic [LEN_W-1:0] KV_DELIM_LEN_RST    = 3'd1;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] key_start;
    logic [FIELD_W-1:0] key_len;
    logic [FIELD_W-1:0] value_start;
    logic [FIELD_W-1:0] value_len;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic [LEN_W-1:0] kv_count;
    logic             kv_off;
    logic             overflow;
  } emit_ctl_t;

endpackage

[sv/kvs_emit.sv]
// ----------------------------------------------------------------------------
// kvs_emit
// Turns one entry span and its kv matches into a map entry word.
// ----------------------------------------------------------------------------
module kvs_emit #(
  parameter int OFFSET_WIDTH = kvs_pkg::OFFSET_WIDTH_DEF
) (
  input  logic [OFFSET_WIDTH-1:0]  ent_begin,
  input  logic [OFFSET_WIDTH-1:0]  ent_stop,
  input  logic [OFFSET_WIDTH-1:0]  end1,
  input  logic [OFFSET_WIDTH-1:0]  end2,
  input  logic [kvs_pkg::LEN_W-1:0] kv_len,
  input  kvs_pkg::emit_ctl_t       ctl,
  output kvs_pkg::res_t            res
);
  import kvs_pkg::*;

  localparam int W = OFFSET_WIDTH;

  function automatic logic [FIELD_W-1:0] to_field(input logic [W-1:0] x);
    logic [W+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, x};
    return t[FIELD_W-1:0];
  endfunction

  logic          tail;
  logic [1:0]    parts;
  logic [W-1:0]  klen_w;
  logic [W-1:0]  key_by_match;

  assign klen_w       = W'(kv_len);
  assign key_by_match = end1 - klen_w - ent_begin;

  always_comb begin
    tail = 1'b0;
    case (ctl.kv_count)
      3'd0:    tail = ent_stop > ent_begin;
      3'd1:    tail = end1 < ent_stop;
      default: tail = end2 < ent_stop;
    endcase
    parts = ctl.kv_count[1:0] + {1'b0, tail};

    res          = '0;
    res.kind     = KIND_ENTRY;
    res.overflow = ctl.overflow;
    // Three or more parts, or no kv delimiter at all, give an empty pair.
    if (!ctl.kv_off && ctl.kv_count < 3'd3) begin
      if (parts == 2'd1) begin
        res.key_start = to_field(ent_begin);
        res.key_len   = (ctl.kv_count == 3'd0) ? to_field(ent_stop - ent_begin)
                                               : to_field(key_by_match);
      end else if (parts == 2'd2) begin
        res.key_start   = to_field(ent_begin);
        res.key_len     = to_field(key_by_match);
        res.value_start = to_field(end1);
        res.value_len   = (ctl.kv_count == 3'd1) ? to_field(ent_stop - end1)
                                                 : to_field(end2 - klen_w - end1);
      end
    end
  end

endmodule

[sv/key_value_string_splitter_core.sv]
// The results of an input word are written into the result queue as the word is taken.
// Throughput: one input word per cycle; a row end adds one or two result words and
// a null row two. The four-deep result queue sets the rate: input is taken while
// two slots are free.
// Reset (synchronous, rst_n low) restores default delimiters and clears the row
// state and the result queue.
// ----------------------------------------------------------------------------
// key_value_string_splitter_core
// Splits row bytes into key/value map entries reported as byte offsets.
// ----------------------------------------------------------------------------
module key_value_string_splitter_core #(
  parameter int DELIM_MAX    = kvs_pkg::DELIM_MAX_DEF,
  parameter int OFFSET_WIDTH = kvs_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kvs_pkg::IN_DATA_W-1:0]   in_tdata,   // data_byte
  input  logic [kvs_pkg::IN_USER_W-1:0]   in_tuser,   // op
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // key_start, key_len, value_start, value_len, overflow, zero fill
  output logic [kvs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [kvs_pkg::OUT_USER_W-1:0]  out_tuser,  // kind
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [kvs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [kvs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [kvs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import kvs_pkg::*;

  localparam int W   = OFFSET_WIDTH;
  localparam int DM  = DELIM_MAX;
  localparam int WB  = 8 * DM;
  localparam logic [W-1:0] OFF_MAX = {W{1'b1}};

  // ---------------- configuration registers ----------------
  logic [31:0]      edelim_r, kdelim_r;
  logic [LEN_W-1:0] elen_r, klen_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edelim_r <= ENTRY_DELIM_RST;
      elen_r   <= ENTRY_DELIM_LEN_RST;
      kdelim_r <= KV_DELIM_RST;
      klen_r   <= KV_DELIM_LEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_ENTRY_DELIM:     edelim_r <= cfg_pwdata;
        REG_ENTRY_DELIM_LEN: elen_r   <= cfg_pwdata[LEN_W-1:0];
        REG_KV_DELIM:        kdelim_r <= cfg_pwdata;
        REG_KV_DELIM_LEN:    klen_r   <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ENTRY_DELIM:     cfg_prdata = edelim_r;
      REG_ENTRY_DELIM_LEN: cfg_prdata = {29'd0, elen_r};
      REG_KV_DELIM:        cfg_prdata = kdelim_r;
      REG_KV_DELIM_LEN:    cfg_prdata = {29'd0, klen_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- delimiter match ----------------
  // The window holds the newest byte in its low byte.
  function automatic logic delim_hit(input logic [31:0] pat, input logic [LEN_W-1:0] len,
                                     input logic [WB-1:0] win, input logic [W-1:0] floor,
                                     input logic [W-1:0] pos);
    logic [WB+31:0] pat_ext;
    logic           ok;
    int             idx;
    pat_ext = {{WB{1'b0}}, pat};
    ok = (len != '0) && (int'(len) <= DM) && ((pos - floor) >= W'(len));
    for (int i = 0; i < DM; i++) begin
      if (i < int'(len)) begin
        idx = int'(len) - 1 - i;
        if (pat_ext[8*i +: 8] != win[8*idx +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // ---------------- row state ----------------
  logic [W-1:0]     pos_r, begin_r, efloor_r, kfloor_r, end0_r, end1_r;
  logic [WB-1:0]    recent_r;
  logic [LEN_W-1:0] kcnt_r;
  logic [DM-1:0]    marks_r;
  logic             rovf_r;

  logic [W-1:0]     pos_nxt, begin_nxt, efloor_nxt, kfloor_nxt, end0_nxt, end1_nxt;
  logic [WB-1:0]    recent_nxt;
  logic [LEN_W-1:0] kcnt_nxt;
  logic [DM-1:0]    marks_nxt;
  logic             rovf_nxt;

  logic             in_acc;
  logic [1:0]       op;
  logic [W-1:0]     cur_end;
  logic [WB+7:0]    win_full;
  logic [WB-1:0]    win;
  logic             kvm, ehit, ovf_cur;
  logic [DM-1:0]    ent_marks;
  logic [LEN_W-1:0] wdrawn;
  // Kv match ends as updated by this byte, before any entry or row clear.
  logic [W-1:0]     end0_pre, end1_pre;

  logic [W-1:0]     em_stop;
  emit_ctl_t        em_ctl;
  res_t             em_res;
  res_t             r0, r1, rowend;
  logic [1:0]       nres;

  assign in_acc   = in_tvalid && in_tready;
  assign op       = in_tuser;
  assign win_full = {recent_r, in_tdata};
  assign win      = win_full[WB-1:0];

  always_comb begin
    ovf_cur  = rovf_r || (pos_r == OFF_MAX);
    cur_end  = (pos_r == OFF_MAX) ? OFF_MAX : pos_r + W'(1);

    kvm        = delim_hit(kdelim_r, klen_r, win, kfloor_r, cur_end);
    kfloor_nxt = kvm ? cur_end : kfloor_r;
    end0_pre   = (kvm && kcnt_r == 3'd0) ? cur_end : end0_r;
    end1_pre   = (kvm && kcnt_r == 3'd1) ? cur_end : end1_r;
    end0_nxt   = end0_pre;
    end1_nxt   = end1_pre;
    kcnt_nxt   = (kvm && kcnt_r != 3'd7) ? kcnt_r + 3'd1 : kcnt_r;
    marks_nxt  = DM'({marks_r, kvm});

    ehit = delim_hit(edelim_r, elen_r, win, efloor_r, cur_end);
    // A kv match ending inside the closing entry delimiter is withdrawn.
    ent_marks = '0;
    for (int i = 0; i < DM; i++) begin
      if (i < int'(elen_r)) ent_marks[i] = marks_nxt[i];
    end
    wdrawn = '0;
    for (int i = 0; i < DM; i++) wdrawn = wdrawn + LEN_W'(ent_marks[i]);

    em_stop         = ehit ? cur_end - W'(elen_r) : cur_end;
    em_ctl.kv_count = ehit ? kcnt_nxt - wdrawn : kcnt_nxt;
    em_ctl.kv_off   = (klen_r == '0);
    em_ctl.overflow = ovf_cur;

    begin_nxt  = begin_r;
    efloor_nxt = efloor_r;
    if (ehit) begin
      begin_nxt  = cur_end;
      efloor_nxt = cur_end;
      kfloor_nxt = cur_end;
      kcnt_nxt   = '0;
      marks_nxt  = '0;
      end0_nxt   = '0;
      end1_nxt   = '0;
    end
    pos_nxt    = cur_end;
    recent_nxt = win;
    rovf_nxt   = ovf_cur;

    rowend          = '0;
    rowend.kind     = KIND_ROW_END;
    rowend.overflow = ovf_cur;
    r0   = em_res;
    r1   = rowend;
    nres = 2'd0;

    if (op == OP_DATA) begin
      if (ehit) begin
        nres = in_tlast ? 2'd2 : 2'd1;
      end else if (in_tlast) begin
        if (elen_r != '0 && begin_r < cur_end) begin
          nres = 2'd2;
        end else begin
          r0   = rowend;
          nres = 2'd1;
        end
      end
    end else if (op == OP_NULL) begin
      r0      = '0;
      r1      = '0;
      r1.kind = KIND_ROW_END;
      nres    = 2'd2;
    end else begin
      r0      = '0;
      r0.kind = KIND_ROW_END;
      nres    = 2'd1;
    end

    // Any row end, null row or empty row starts a fresh row.
    if (op != OP_DATA || in_tlast) begin
      pos_nxt    = '0;
      begin_nxt  = '0;
      efloor_nxt = '0;
      kfloor_nxt = '0;
      end0_nxt   = '0;
      end1_nxt   = '0;
      recent_nxt = '0;
      kcnt_nxt   = '0;
      marks_nxt  = '0;
      rovf_nxt   = 1'b0;
    end
  end

  kvs_emit #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_emit (
    .ent_begin (begin_r),
    .ent_stop  (em_stop),
    .end1      (end0_pre),
    .end2      (end1_pre),
    .kv_len    (klen_r),
    .ctl       (em_ctl),
    .res       (em_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      begin_r  <= '0;
      efloor_r <= '0;
      kfloor_r <= '0;
      end0_r   <= '0;
      end1_r   <= '0;
      recent_r <= '0;
      kcnt_r   <= '0;
      marks_r  <= '0;
      rovf_r   <= 1'b0;
    end else if (in_acc) begin
      pos_r    <= pos_nxt;
      begin_r  <= begin_nxt;
      efloor_r <= efloor_nxt;
      kfloor_r <= kfloor_nxt;
      end0_r   <= end0_nxt;
      end1_r   <= end1_nxt;
      recent_r <= recent_nxt;
      kcnt_r   <= kcnt_nxt;
      marks_r  <= marks_nxt;
      rovf_r   <= rovf_nxt;
    end
  end

  // ---------------- result queue ----------------
  res_t       q_mem [4];
  logic [1:0] wr_r, rd_r, wr_nxt, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] push_n;
  logic       pop;
  res_t       head;

  assign in_tready  = (cnt_r <= 3'd2);
  assign push_n     = in_acc ? nres : 2'd0;
  assign out_tvalid = (cnt_r != 3'd0);
  assign pop        = out_tvalid && out_tready;
  assign head       = q_mem[rd_r];
  assign out_tuser  = head.kind;
  assign out_tdata  = {7'd0, head.overflow, head.value_len, head.value_start,
                       head.key_len, head.key_start};

  always_comb begin
    wr_nxt  = wr_r + push_n;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_mem[wr_r] <= r0;
    if (push_n == 2'd2) q_mem[wr_r + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/kvs_checker.sv]
// ----------------------------------------------------------------------------
// kvs_checker
// Port-level checks of the key/value splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_value_string_splitter_core_assert.svh"

module kvs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [kvs_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [kvs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [kvs_pkg::OUT_USER_W-1:0] out_tuser
);
  import kvs_pkg::*;

  // A stalled result word stays offered.
  `KVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // Nothing is offered right after reset.
  `KVS_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_tvalid)
  // A null row always produces words on the next cycle.
  `KVS_ASSERT_NEXT(a_null_out, clk, rst_n,
    in_tvalid && in_tready && in_tuser == OP_NULL, out_tvalid)
  // Row-end words carry no offsets.
  `KVS_ASSERT_NOW(a_rowend_zero, clk, rst_n,
    out_tvalid && out_tuser[0] == KIND_ROW_END, out_tdata[63:0] == 64'd0)

endmodule

bind key_value_string_splitter_core kvs_checker u_kvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value splitter testbench
// Streams row bytes into the splitter and compares every entry and row-end
// word against an in-bench model of the splitting rules, across several
// delimiter settings written over the register port.
// ----------------------------------------------------------------------------
module testbench;
  import kvs_pkg::*;

  class kv_entry_board;
    // Delimiter settings currently loaded into the block.
    logic [31:0] ent_pat;
    logic [2:0]  ent_len;
    logic [31:0] kv_pat;
    logic [2:0]  kv_len;
    // Row state.
    int unsigned pos;
    int unsigned ent_begin;
    logic [23:0] history;
    int unsigned ent_floor;
    int unsigned kv_floor;
    int unsigned kv_end0;
    int unsigned kv_end1;
    int unsigned kv_count;
    logic [3:0]  kv_marks;
    bit          ovf;
    res_t        pending[$];
    int          errors;

    function new();
      ent_pat = ENTRY_DELIM_RST;
      ent_len = ENTRY_DELIM_LEN_RST;
      kv_pat  = KV_DELIM_RST;
      kv_len  = KV_DELIM_LEN_RST;
      errors  = 0;
      clear_row();
    endfunction

    function void clear_row();
      pos = 0; ent_begin = 0; history = '0; ent_floor = 0; kv_floor = 0;
      kv_end0 = 0; kv_end1 = 0; kv_count = 0; kv_marks = '0; ovf = 0;
    endfunction

    function void push(logic kind, int unsigned ks, int unsigned kl,
                       int unsigned vs, int unsigned vl, bit of);
      res_t r;
      r.kind = kind; r.key_start = ks[15:0]; r.key_len = kl[15:0];
      r.value_start = vs[15:0]; r.value_len = vl[15:0]; r.overflow = of;
      pending.push_back(r);
    endfunction

    function bit delim_match(logic [31:0] pat, logic [2:0] len, logic [31:0] win,
                             int unsigned floor_pos, int unsigned end_pos);
      if (len == 0 || len > 4) return 0;
      if (end_pos < floor_pos + len) return 0;
      for (int i = 0; i < len; i++)
        if (pat[8*i +: 8] != win[8*(len-1-i) +: 8]) return 0;
      return 1;
    endfunction

    function void entry_out(int unsigned b, int unsigned s, int unsigned m);
      int unsigned k;
      int unsigned tail;
      int unsigned parts;
      k = kv_len;
      if (k == 0 || m >= 3) begin
        push(KIND_ENTRY, 0, 0, 0, 0, ovf);
        return;
      end
      if (m == 0) tail = (s > b);
      else if (m == 1) tail = (kv_end0 < s);
      else tail = (kv_end1 < s);
      parts = m + tail;
      if (parts == 1) begin
        if (m == 0) push(KIND_ENTRY, b, s - b, 0, 0, ovf);
        else push(KIND_ENTRY, b, kv_end0 - k - b, 0, 0, ovf);
      end else if (parts == 2) begin
        if (m == 1) push(KIND_ENTRY, b, kv_end0 - k - b, kv_end0, s - kv_end0, ovf);
        else push(KIND_ENTRY, b, kv_end0 - k - b, kv_end0, kv_end1 - k - kv_end0, ovf);
      end else begin
        push(KIND_ENTRY, 0, 0, 0, 0, ovf);
      end
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] data, bit last);
      int unsigned end_pos;
      logic [31:0] win;
      bit kv_hit;
      int unsigned withdrawn;
      if (op == OP_NULL) begin
        clear_row();
        push(KIND_ENTRY, 0, 0, 0, 0, 0);
        push(KIND_ROW_END, 0, 0, 0, 0, 0);
        return;
      end
      if (op != OP_DATA) begin
        clear_row();
        push(KIND_ROW_END, 0, 0, 0, 0, 0);
        return;
      end
      if (pos < 65535) end_pos = pos + 1;
      else begin
        end_pos = 65535;
        ovf = 1;
      end
      win = {history, data};
      kv_hit = delim_match(kv_pat, kv_len, win, kv_floor, end_pos);
      if (kv_hit) begin
        kv_floor = end_pos;
        if (kv_count == 0) kv_end0 = end_pos;
        else if (kv_count == 1) kv_end1 = end_pos;
        if (kv_count < 7) kv_count++;
      end
      kv_marks = {kv_marks[2:0], kv_hit};
      if (delim_match(ent_pat, ent_len, win, ent_floor, end_pos)) begin
        // kv matches ending inside the closing entry delimiter are withdrawn.
        withdrawn = 0;
        for (int i = 0; i < 4; i++)
          if (i < ent_len && kv_marks[i]) withdrawn++;
        entry_out(ent_begin, end_pos - ent_len, kv_count - withdrawn);
        ent_begin = end_pos; ent_floor = end_pos; kv_floor = end_pos;
        kv_count = 0; kv_marks = '0; kv_end0 = 0; kv_end1 = 0;
      end
      pos = end_pos;
      history = win[23:0];
      if (last) begin
        if (ent_len != 0 && ent_begin < end_pos) entry_out(ent_begin, end_pos, kv_count);
        push(KIND_ROW_END, 0, 0, 0, 0, ovf);
        clear_row();
      end
    endfunction

    task report(string what, res_t got, res_t want);
      errors++;
      $display("mismatch %s: got %p expected %p", what, got, want);
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got, '0);
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) report("kind", got, want);
      if (got.key_start !== want.key_start) report("key_start", got, want);
      if (got.key_len !== want.key_len) report("key_len", got, want);
      if (got.value_start !== want.value_start) report("value_start", got, want);
      if (got.value_len !== want.value_len) report("value_len", got, want);
      if (got.overflow !== want.overflow) report("overflow", got, want);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  kv_entry_board board = new();
  bit quiet_phase = 0;
  int idle_cycles = 0;
  int out_stall = 0;
  localparam int WATCHDOG_LIMIT = 200000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_value_string_splitter_core u_dut (.*);

  // Sink side: random stall bursts, checking on each accepted word.
  always @(posedge clk) begin
    res_t r;
    if (rst_n && out_tvalid && out_tready) begin
      r.kind = out_tuser[0];
      r.key_start = out_tdata[15:0];
      r.key_len = out_tdata[31:16];
      r.value_start = out_tdata[47:32];
      r.value_len = out_tdata[63:48];
      r.overflow = out_tdata[64];
      board.check_result(r);
    end
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      out_stall <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_ENTRY_DELIM:     board.ent_pat = value;
      REG_ENTRY_DELIM_LEN: board.ent_len = value[2:0];
      REG_KV_DELIM:        board.kv_pat = value;
      default:             board.kv_len = value[2:0];
    endcase
  endtask

  task set_delims(logic [31:0] ep, logic [2:0] el, logic [31:0] kp, logic [2:0] kl);
    write_reg(REG_ENTRY_DELIM, ep);
    write_reg(REG_ENTRY_DELIM_LEN, {29'd0, el});
    write_reg(REG_KV_DELIM, kp);
    write_reg(REG_KV_DELIM_LEN, {29'd0, kl});
  endtask

  // Sends one word, with an occasional idle burst ahead of it.
  task send_word(logic [1:0] op, logic [7:0] data, bit last);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tuser <= op; in_tdata <= data; in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    board.note_input(op, data, last);
  endtask

  task finish_phase();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random byte mostly drawn from the delimiter bytes so matches occur often.
  function logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return board.ent_pat[8*$urandom_range(0, 3) +: 8];
    if (sel < 6) return board.kv_pat[8*$urandom_range(0, 3) +: 8];
    if (sel < 8) return 8'(8'h61 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // An op that closes a row without data: empty row or the spare code.
  function logic [1:0] pick_empty_op();
    return ($urandom_range(0, 1) == 0) ? OP_EMPTY : OP_SPARE;
  endfunction

  // An op that breaks off a row: null row, empty row or the spare code.
  function logic [1:0] pick_break_op();
    case ($urandom_range(0, 2))
      0:       return OP_NULL;
      1:       return OP_EMPTY;
      default: return OP_SPARE;
    endcase
  endfunction

  task send_row(int n);
    for (int i = 0; i < n; i++) send_word(OP_DATA, pick_byte(), i == n - 1);
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_DATA, s[i], i == s.len() - 1);
  endtask

  task random_items(int count);
    int k;
    int sent;
    sent = 0;
    while (sent < count) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        send_word(OP_NULL, 8'($urandom), 1'($urandom));
        sent++;
      end else if (k == 1) begin
        send_word(pick_empty_op(), 8'($urandom), 1'($urandom));
        sent++;
      end else if (k == 2) begin
        // A row cut short by a null or empty row.
        for (int i = 0; i < 3; i++) send_word(OP_DATA, pick_byte(), 1'b0);
        send_word(pick_break_op(), 8'($urandom), 1'($urandom));
        sent += 4;
      end else begin
        k = $urandom_range(1, 14);
        send_row(k);
        sent += k;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows with the reset delimiters.
    send_text("a=b,c,d=e=f,");
    send_text("x=,=y");
    send_word(OP_NULL, 8'h00, 1'b0);
    send_word(OP_EMPTY, 8'h00, 1'b0);
    send_word(OP_SPARE, 8'hff, 1'b1);
    send_word(OP_DATA, 8'hff, 1'b0);
    send_word(OP_DATA, 8'h00, 1'b0);
    send_word(OP_NULL, 8'h00, 1'b1);
    finish_phase();

    // Multi-byte delimiters where kv overlaps the entry delimiter.
    set_delims(32'h0000_3b3b, 3'd2, 32'h0000_3b3a, 3'd2);
    send_text("k:;v;;k:;;");
    random_items(200);
    finish_phase();

    set_delims(32'hffff_ffff, 3'd4, 32'h0000_0000, 3'd4);
    random_items(200);
    finish_phase();

    set_delims(32'h0000_002c, 3'd0, 32'h0000_003d, 3'd0);
    random_items(100);
    finish_phase();

    set_delims(32'h0000_002c, 3'd7, 32'h0000_003d, 3'd1);
    random_items(100);
    finish_phase();

    set_delims(32'h0000_002c, 3'd1, 32'h0000_3d3d, 3'd5);
    random_items(100);
    finish_phase();

    set_delims(32'h2c2c_3b2c, 3'd3, 32'h003d_3d61, 3'd3);
    random_items(560);
    quiet_phase = 1;
    random_items(100);
    finish_phase();

    if (board.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/kvs_pkg.sv
sv/kvs_emit.sv
sv/key_value_string_splitter_core.sv
sv/kvs_checker.sv
tb/testbench.sv
